/* design/ptbe_pkg.sv */
// ----------------------------------------------------------------------------
// ptbe_pkg
// Shared constants, codes and small tables for the pitch trajectory basis
// evaluator: Q formats, Q30 constants for sine, log2 and exp2, and codes.
// ----------------------------------------------------------------------------
package ptbe_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned TW = FRAC_BITS + 1;

	localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

	localparam logic [30:0] Q30 = 31'h4000_0000;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	localparam logic [30:0] SINE_S1 = 31'd1686629713;
	localparam logic [30:0] SINE_S3 = 31'd693598668;
	localparam logic [30:0] SINE_S5 = 31'd85569306;
	localparam logic [30:0] SINE_S7 = 31'd5026995;
	localparam logic [30:0] SINE_S9 = 31'd172272;
	localparam logic [30:0] SINE_S11 = 31'd3864;

	// power of two in Q30 underflows to zero from this exponent on
	localparam logic [47:0] MM_LIMIT = 48'd40 << 30;

	typedef enum logic [2:0] {
		SHAPE_STABLE  = 3'd0,
		SHAPE_ONSET   = 3'd1,
		SHAPE_RELEASE = 3'd2,
		SHAPE_VIBRATO = 3'd3,
		SHAPE_ATTRACT = 3'd4
	} shape_kind_t;

	typedef enum logic [2:0] {
		REG_SHAPE_KIND     = 3'd0,
		REG_RAMP_DURATION  = 3'd1,
		REG_VIBRATO_RATE   = 3'd2,
		REG_VIBRATO_EXTENT = 3'd3,
		REG_ATTRACT_AMOUNT = 3'd4,
		REG_ATTRACT_SKEW   = 3'd5
	} cfg_reg_t;

	// Horner coefficients of the sine polynomial, highest power after z^11 first
	function automatic logic [30:0] sine_coef(input int unsigned idx);
		logic [30:0] c;
		case (idx)
			0:       c = SINE_S9;
			1:       c = SINE_S7;
			2:       c = SINE_S5;
			3:       c = SINE_S3;
			default: c = SINE_S1;
		endcase
		return c;
	endfunction

endpackage

/* design/ptbe_exp2.sv */
// ----------------------------------------------------------------------------
// ptbe_exp2
// Pipelined 2^f in Q30 for a Q30 fraction f: degree-10 series of e^(f*ln2)
// by truncating Horner steps, 29 register stages, moves when en is high.
// ----------------------------------------------------------------------------
module ptbe_exp2 (
	input  logic        clk,
	input  logic        en,
	input  logic [29:0] frac,
	output logic [30:0] value
);

	logic [29:0] w_s1;
	wire  [29:0] bw [0:9];
	wire  [30:0] bp [0:9];

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= 30'((60'(frac) * 60'(ptbe_pkg::LN2_Q30)) >> 30);
		end
	end

	assign bw[0] = w_s1;
	assign bp[0] = ptbe_pkg::Q30;

	// each term divides by k: multiply, reciprocal estimate, one-step correct
	for (genvar s = 0; s < 9; s++) begin : g_step
		localparam int unsigned K = 10 - s;
		localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(K));

		logic [30:0] a_sa;
		logic [29:0] w_sa;
		logic [30:0] a_sb;
		logic [30:0] qm_sb;
		logic [29:0] w_sb;
		logic [30:0] p_sc;
		logic [29:0] w_sc;
		logic [30:0] rem;
		logic [30:0] quo;

		always_comb begin
			rem = a_sb - 31'(qm_sb * 31'(K));
			quo = (rem >= 31'(K)) ? qm_sb + 31'd1 : qm_sb;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_sa  <= 31'((61'(bw[s]) * 61'(bp[s])) >> 30);
				w_sa  <= bw[s];
				qm_sb <= 31'((63'(a_sa) * 63'(RECIP)) >> 32);
				a_sb  <= a_sa;
				w_sb  <= w_sa;
				p_sc  <= ptbe_pkg::Q30 + quo;
				w_sc  <= w_sb;
			end
		end

		assign bw[s+1] = w_sc;
		assign bp[s+1] = p_sc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value <= 31'(61'(ptbe_pkg::Q30) + ((61'(bw[9]) * 61'(bp[9])) >> 30));
		end
	end

endmodule

/* design/pitch_trajectory_basis_eval.sv */
// ----------------------------------------------------------------------------
// pitch_trajectory_basis_eval
// Clamps a Q8.16 time sample to 0..1 and evaluates the configured basis
// shape: stable, smoothstep onset or release, sine vibrato or power attraction.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid, in_stall, time_in) carry one time sample each.
//   Output beats (out_valid, out_stall, basis_value) carry one Q8.16 value,
//   saturated, for every input beat, in order.
//   Registers are written through cfg_we, cfg_index and cfg_data; the user
//   must write them only while no beat is in flight, as the block does not
//   enforce it. Unknown indexes are dropped. Throughput is one beat per cycle
//   while out_stall is low. The longest path through the 68 stages is the
//   attraction chain: a 29-stage exp2 unit beside a 30-stage log2 squaring
//   chain, then a second 29-stage exp2 unit.
//   Reset clears the configuration registers and the pipeline valid bits.
//   When out_stall is high with a result waiting, the whole pipeline holds,
//   bubbles included, and in_stall goes high.
// ----------------------------------------------------------------------------
module pitch_trajectory_basis_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] time_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] basis_value,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam int unsigned TW = ptbe_pkg::TW;
	localparam int unsigned LAST = 68;

	// configuration
	logic [2:0]         kind_q;
	logic [17:0]        dur_q;
	logic signed [23:0] rate_q;
	logic signed [23:0] ext_q;
	logic signed [23:0] amt_q;
	logic signed [19:0] skew_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
			dur_q  <= '0;
			rate_q <= '0;
			ext_q  <= '0;
			amt_q  <= '0;
			skew_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptbe_pkg::REG_SHAPE_KIND:     kind_q <= cfg_data[2:0];
				ptbe_pkg::REG_RAMP_DURATION:  dur_q  <= cfg_data[17:0];
				ptbe_pkg::REG_VIBRATO_RATE:   rate_q <= cfg_data;
				ptbe_pkg::REG_VIBRATO_EXTENT: ext_q  <= cfg_data;
				ptbe_pkg::REG_ATTRACT_AMOUNT: amt_q  <= cfg_data;
				ptbe_pkg::REG_ATTRACT_SKEW:   skew_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// pipeline control: valid bits travel with the data
	logic       adv;
	logic       vld_s [1:LAST];

	assign adv       = !(vld_s[LAST] && out_stall);
	assign in_stall  = vld_s[LAST] && out_stall;
	assign out_valid = vld_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= LAST; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// stage 1: clamp
	logic [TW-1:0] t_clamp;
	logic [TW-1:0] t_s1;

	always_comb begin
		if (time_in[23]) begin
			t_clamp = '0;
		end else if (time_in > 24'sd65536) begin
			t_clamp = ptbe_pkg::ONE;
		end else begin
			t_clamp = time_in[TW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) t_s1 <= t_clamp;
	end

	// ------------------------------------------------------------------ ramp
	logic [TW-1:0] num;
	logic          rone;
	logic          rone_s   [2:11];
	logic [17:0]   dv_rem_s [2:10];
	logic [15:0]   dv_q_s   [2:10];
	logic [17:0]   dv_rem_n [3:10];
	logic [15:0]   dv_q_n   [3:10];
	logic [15:0]   x2_s11;
	logic [17:0]   pm_s11;
	logic [17:0]   ramp_s   [12:67];

	always_comb begin
		if (kind_q == ptbe_pkg::SHAPE_RELEASE) begin
			num  = ptbe_pkg::ONE - t_s1;
			rone = (dur_q == '0) ||
				((19'(t_s1) + 19'(dur_q)) <= 19'(ptbe_pkg::ONE));
		end else begin
			num  = t_s1;
			rone = (dur_q == '0) || (18'(t_s1) >= dur_q);
		end
	end

	// restoring division, two quotient bits per stage
	always_comb begin
		logic [18:0] r2;
		logic [17:0] r;
		logic [15:0] q;
		for (int j = 3; j <= 10; j++) begin
			r = dv_rem_s[j-1];
			q = dv_q_s[j-1];
			for (int b = 0; b < 2; b++) begin
				r2 = {r, 1'b0};
				if (r2 >= 19'(dur_q)) begin
					r2 = r2 - 19'(dur_q);
					q  = {q[14:0], 1'b1};
				end else begin
					q  = {q[14:0], 1'b0};
				end
				r = r2[17:0];
			end
			dv_rem_n[j] = r;
			dv_q_n[j]   = q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rone_s[2]   <= rone;
			dv_rem_s[2] <= 18'(num);
			dv_q_s[2]   <= '0;
			for (int j = 3; j <= 10; j++) begin
				dv_rem_s[j] <= dv_rem_n[j];
				dv_q_s[j]   <= dv_q_n[j];
			end
			for (int j = 3; j <= 11; j++) rone_s[j] <= rone_s[j-1];
			x2_s11    <= 16'((32'(dv_q_s[10]) * 32'(dv_q_s[10])) >> 16);
			pm_s11    <= 18'd196608 - {1'b0, dv_q_s[10], 1'b0};
			ramp_s[12] <= rone_s[11] ? 18'(ptbe_pkg::ONE) :
				18'((34'(x2_s11) * 34'(pm_s11)) >> 16);
			for (int j = 13; j <= 67; j++) ramp_s[j] <= ramp_s[j-1];
		end
	end

	// --------------------------------------------------------------- vibrato
	logic signed [41:0] ph_prod;
	logic [31:0]        ph_s2;
	logic [30:0]        z_s   [3:9];
	logic               neg_s [3:10];
	logic [30:0]        z2_s  [4:8];
	logic [30:0]        hp_s  [4:9];
	logic [30:0]        sine_s10;
	logic signed [31:0] sine_sg;
	logic signed [55:0] vprod;
	logic signed [25:0] vib_s [11:67];

	assign ph_prod = rate_q * $signed({1'b0, t_s1});
	assign sine_sg = neg_s[10] ? -$signed({1'b0, sine_s10}) : $signed({1'b0, sine_s10});
	assign vprod   = ext_q * sine_sg;

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s2    <= ph_prod[31:0];
			// fold the phase into a quarter wave
			z_s[3]   <= ph_s2[30] ? ptbe_pkg::Q30 - {1'b0, ph_s2[29:0]} : {1'b0, ph_s2[29:0]};
			neg_s[3] <= ph_s2[31];
			z2_s[4]  <= 31'((62'(z_s[3]) * 62'(z_s[3])) >> 30);
			hp_s[4]  <= ptbe_pkg::SINE_S11;
			for (int j = 4; j <= 9; j++) z_s[j] <= z_s[j-1];
			for (int j = 4; j <= 10; j++) neg_s[j] <= neg_s[j-1];
			for (int j = 5; j <= 8; j++) z2_s[j] <= z2_s[j-1];
			for (int j = 5; j <= 9; j++) begin
				hp_s[j] <= 31'(32'(ptbe_pkg::sine_coef(j - 5)) -
					32'((62'(z2_s[j-1]) * 62'(hp_s[j-1])) >> 30));
			end
			sine_s10  <= 31'((62'(z_s[9]) * 62'(hp_s[9])) >> 30);
			vib_s[11] <= vprod[55:30];
			for (int j = 12; j <= 67; j++) vib_s[j] <= vib_s[j-1];
		end
	end

	// ------------------------------------------------------------ attraction
	logic signed [51:0] uprod;
	logic signed [4:0]  ei_s  [2:31];
	logic [29:0]        ef_s2;
	logic [30:0]        eva;
	logic [45:0]        ex_wide;
	logic [41:0]        ex_s32;
	logic [41:0]        ex_s33;
	logic               tz_s  [2:66];
	logic [4:0]         ln0;
	logic [46:0]        m0_wide;
	logic [30:0]        lm_s  [2:32];
	logic [29:0]        lf_s  [2:32];
	logic [4:0]         ln_s  [2:32];
	logic [30:0]        lm_n  [3:32];
	logic [29:0]        lf_n  [3:32];
	logic [34:0]        nl_s33;
	logic [29:0]        pll_s34;
	logic [41:0]        phl_s34;
	logic [29:0]        el_s34;
	logic [11:0]        eh_s34;
	logic [4:0]         nh_s34;
	logic [47:0]        mm_s35;
	logic               big_s [36:65];
	logic [5:0]         ip_s  [36:65];
	logic               fz_s  [36:65];
	logic [29:0]        fexp_s36;
	logic [30:0]        evb;
	logic [30:0]        x_s66;
	logic signed [55:0] aprod;
	logic signed [25:0] att_s67;

	assign uprod = skew_q * $signed({1'b0, ptbe_pkg::LOG2E_Q30});
	assign aprod = amt_q * $signed({1'b0, x_s66});

	// leading one of the clamped time
	always_comb begin
		ln0 = '0;
		for (int k = 0; k < int'(TW); k++) begin
			if (t_s1[k]) ln0 = 5'(k);
		end
		m0_wide = 47'(t_s1) << (5'd30 - ln0);
	end

	// one fraction bit of log2 per squaring
	always_comb begin
		logic [31:0] m2;
		for (int j = 3; j <= 32; j++) begin
			m2      = 32'((62'(lm_s[j-1]) * 62'(lm_s[j-1])) >> 30);
			lf_n[j] = lf_s[j-1];
			if (m2[31]) begin
				lm_n[j]         = m2[31:1];
				lf_n[j][32 - j] = 1'b1;
			end else begin
				lm_n[j]         = m2[30:0];
			end
		end
	end

	// scale 2^f by the integer part of the exponent
	always_comb begin
		if (ei_s[31][4]) begin
			ex_wide = 46'(eva) >> (5'd0 - ei_s[31]);
		end else begin
			ex_wide = 46'(eva) << ei_s[31];
		end
	end

	ptbe_exp2 u_exp_skew (
		.clk   (clk),
		.en    (adv),
		.frac  (ef_s2),
		.value (eva)
	);

	ptbe_exp2 u_exp_out (
		.clk   (clk),
		.en    (adv),
		.frac  (fexp_s36),
		.value (evb)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ei_s[2] <= uprod[50:46];
			ef_s2   <= uprod[45:16];
			for (int j = 3; j <= 31; j++) ei_s[j] <= ei_s[j-1];
			ex_s32  <= ex_wide[41:0];
			ex_s33  <= ex_s32;

			tz_s[2] <= (t_s1 == '0);
			for (int j = 3; j <= 66; j++) tz_s[j] <= tz_s[j-1];
			lm_s[2] <= m0_wide[30:0];
			lf_s[2] <= '0;
			ln_s[2] <= ln0;
			for (int j = 3; j <= 32; j++) begin
				lm_s[j] <= lm_n[j];
				lf_s[j] <= lf_n[j];
				ln_s[j] <= ln_s[j-1];
			end
			nl_s33 <= {5'(5'd16 - ln_s[32]), 30'b0} - {5'b0, lf_s[32]};

			// exponent product split into high and low Q30 halves
			pll_s34 <= 30'((60'(ex_s33[29:0]) * 60'(nl_s33[29:0])) >> 30);
			phl_s34 <= 42'(ex_s33[41:30]) * 42'(nl_s33[29:0]);
			el_s34  <= ex_s33[29:0];
			eh_s34  <= ex_s33[41:30];
			nh_s34  <= nl_s33[34:30];
			mm_s35  <= {1'b0, 17'(eh_s34) * 17'(nh_s34), 30'b0} + 48'(phl_s34) +
				48'(el_s34) * 48'(nh_s34) + 48'(pll_s34);

			big_s[36] <= (mm_s35 >= ptbe_pkg::MM_LIMIT);
			ip_s[36]  <= mm_s35[35:30];
			fz_s[36]  <= (mm_s35[29:0] == '0);
			fexp_s36  <= 30'(ptbe_pkg::Q30 - {1'b0, mm_s35[29:0]});
			for (int j = 37; j <= 65; j++) begin
				big_s[j] <= big_s[j-1];
				ip_s[j]  <= ip_s[j-1];
				fz_s[j]  <= fz_s[j-1];
			end

			if (big_s[65]) begin
				x_s66 <= '0;
			end else if (fz_s[65]) begin
				x_s66 <= ptbe_pkg::Q30 >> ip_s[65];
			end else begin
				x_s66 <= evb >> (7'(ip_s[65]) + 7'd1);
			end
			att_s67 <= tz_s[66] ? '0 : aprod[55:30];
		end
	end

	// ---------------------------------------------------------------- output
	function automatic logic [23:0] sat26(input logic signed [25:0] v);
		logic [23:0] r;
		if (v > 26'sd8388607) begin
			r = 24'h7F_FFFF;
		end else if (v < -26'sd8388608) begin
			r = 24'h80_0000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	logic [23:0] result;

	always_comb begin
		unique case (kind_q) inside
			ptbe_pkg::SHAPE_STABLE:                          result = 24'(ptbe_pkg::ONE);
			ptbe_pkg::SHAPE_ONSET, ptbe_pkg::SHAPE_RELEASE:  result = 24'(ramp_s[67]);
			ptbe_pkg::SHAPE_VIBRATO:                         result = sat26(vib_s[67]);
			ptbe_pkg::SHAPE_ATTRACT:                         result = sat26(att_s67);
			default:                                         result = '0;
		endcase
	end

	logic [23:0] basis_value_s68;

	always_ff @(posedge clk) begin
		if (adv) basis_value_s68 <= result;
	end

	assign basis_value = basis_value_s68;

endmodule

/* tb/pitch_trajectory_basis_eval_tb.sv */
// ----------------------------------------------------------------------------
// pitch_trajectory_basis_eval_tb
// Drives time samples through the basis evaluator under many register
// settings. Every output beat is checked against a bit-exact fixed-point
// model of each shape. Both handshakes see random idle and stall cycles.
// ----------------------------------------------------------------------------
module pitch_trajectory_basis_eval_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam logic [2:0] SHAPE_UNUSED = 3'd7;
	localparam longint ONE_I = longint'(1) << ptbe_pkg::FRAC_BITS;
	localparam longint LATENCY = 68;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [23:0] time_in;
	logic               out_valid;
	logic               out_stall;
	logic signed [23:0] basis_value;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [23:0]        cfg_data;

	// register mirror, sign-extended where the register is signed
	logic [2:0] shape_q;
	longint     dur_q, rate_q, ext_q, amt_q, skew_q;

	logic signed [23:0] pending_times[$];
	logic signed [23:0] expected_values[$];
	int                 gap_left, stall_left, fail_count, beats_checked, phase_count;
	bit                 idle_on;

	pitch_trajectory_basis_eval DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .time_in(time_in),
		.out_valid(out_valid), .out_stall(out_stall), .basis_value(basis_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint smoothstep_q(longint x);
		bit [63:0] x2, p;
		x2 = (64'(x) * 64'(x)) >> ptbe_pkg::FRAC_BITS;
		p = 64'(3 * ONE_I - 2 * x);
		return longint'((x2 * p) >> ptbe_pkg::FRAC_BITS);
	endfunction

	function automatic longint sine_q30(bit [31:0] ph);
		bit [63:0] f, z, z2, p, q30;
		q30 = 64'(ptbe_pkg::Q30);
		f = 64'(ph[29:0]);
		z = ph[30] ? q30 - f : f;
		z2 = (z * z) >> 30;
		p = 64'(ptbe_pkg::SINE_S11);
		p = 64'(ptbe_pkg::SINE_S9) - ((z2 * p) >> 30);
		p = 64'(ptbe_pkg::SINE_S7) - ((z2 * p) >> 30);
		p = 64'(ptbe_pkg::SINE_S5) - ((z2 * p) >> 30);
		p = 64'(ptbe_pkg::SINE_S3) - ((z2 * p) >> 30);
		p = 64'(ptbe_pkg::SINE_S1) - ((z2 * p) >> 30);
		p = (z * p) >> 30;
		return ph[31] ? -longint'(p) : longint'(p);
	endfunction

	// 2^(f / 2^30) in Q30, f taken modulo 2^30
	function automatic bit [63:0] pow2_frac_q30(bit [63:0] f);
		bit [63:0] w, p;
		w = ((f & 64'(ptbe_pkg::Q30 - 1)) * 64'(ptbe_pkg::LN2_Q30)) >> 30;
		p = 64'(ptbe_pkg::Q30);
		for (int k = 10; k >= 1; k--)
			p = 64'(ptbe_pkg::Q30) + ((w * p) >> 30) / 64'(k);
		return p;
	endfunction

	function automatic longint attraction_q(longint t);
		longint    u, i, log2e;
		bit [63:0] v, ex, ut, m, frac, nl, eh, el, nh, nlo, mm, fp, x;
		int        n, ip;
		log2e = longint'(ptbe_pkg::LOG2E_Q30);
		u = (skew_q * log2e) >>> ptbe_pkg::FRAC_BITS;
		i = u >>> 30;
		v = pow2_frac_q30(64'(u - i * longint'(ptbe_pkg::Q30)));
		ex = (i >= 0) ? (v << i) : (v >> (-i));
		ut = 64'(t);
		n = 0;
		while ((ut >> (n + 1)) != 0)
			n++;
		m = ut << (30 - n);
		frac = 0;
		for (int b = 0; b < 30; b++) begin
			m = (m * m) >> 30;
			if (m >= 2 * 64'(ptbe_pkg::Q30)) begin
				m = m >> 1;
				frac |= 64'(1) << (29 - b);
			end
		end
		nl = (64'(ptbe_pkg::FRAC_BITS - n) << 30) - frac;
		eh = ex >> 30;
		el = ex & 64'(ptbe_pkg::Q30 - 1);
		nh = nl >> 30;
		nlo = nl & 64'(ptbe_pkg::Q30 - 1);
		mm = ((eh * nh) << 30) + eh * nlo + el * nh + ((el * nlo) >> 30);
		if (mm >= 64'(ptbe_pkg::MM_LIMIT))
			return 0;
		ip = int'(mm >> 30);
		fp = mm & 64'(ptbe_pkg::Q30 - 1);
		x = (fp == 0) ? (64'(ptbe_pkg::Q30) >> ip)
			: (pow2_frac_q30(64'(ptbe_pkg::Q30) - fp) >> (ip + 1));
		return (amt_q * longint'(x)) >>> 30;
	endfunction

	function automatic logic signed [23:0] predict_basis(logic signed [23:0] tin);
		longint    t, r, prod;
		bit [63:0] ut;
		t = longint'(tin);
		if (t < 0) t = 0;
		if (t > ONE_I) t = ONE_I;
		r = 0;
		case (shape_q)
			ptbe_pkg::SHAPE_STABLE: r = ONE_I;
			ptbe_pkg::SHAPE_ONSET: begin
				if (dur_q == 0 || t >= dur_q) r = ONE_I;
				else r = smoothstep_q((t << ptbe_pkg::FRAC_BITS) / dur_q);
			end
			ptbe_pkg::SHAPE_RELEASE: begin
				if (dur_q == 0 || t <= ONE_I - dur_q) r = ONE_I;
				else r = smoothstep_q(((ONE_I - t) << ptbe_pkg::FRAC_BITS) / dur_q);
			end
			ptbe_pkg::SHAPE_VIBRATO: begin
				prod = rate_q * t;
				ut = 64'(prod);
				r = (ext_q * sine_q30(ut[31:0])) >>> 30;
			end
			ptbe_pkg::SHAPE_ATTRACT: r = (t == 0) ? 0 : attraction_q(t);
			default: r = 0;
		endcase
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r[23:0];
	endfunction

	// driver: one beat per pending sample, idle gap drawn per beat
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			time_in <= '0;
			gap_left = 0;
		end else begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				expected_values.push_back(predict_basis(time_in));
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_times.size() > 0) begin
					time_in <= pending_times.pop_front();
					busy = 1'b1;
					gap_left = idle_on ? $urandom_range(0, 16) : 0;
				end
			end
			in_valid <= busy;
		end
	end

	// monitor: check each accepted beat, stall drawn per beat
	always @(posedge clk or negedge arst_n) begin
		logic signed [23:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					$error("basis_value: unexpected beat, value %0d", basis_value);
					fail_count++;
				end else begin
					want = expected_values.pop_front();
					if (basis_value !== want) begin
						$error("basis_value expected %0d got %0d", want, basis_value);
						fail_count++;
					end
					beats_checked++;
				end
				stall_left = idle_on ? $urandom_range(0, 16) : 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0);
		end
	end

	// write all registers in back-to-back cycles, then one dropped write
	task automatic set_regs(logic [2:0] kind, logic [17:0] dur, logic [23:0] rate,
			logic [23:0] ext, logic [23:0] amt, logic [19:0] skew);
		logic [23:0] vals[6];
		vals = '{24'(kind), 24'(dur), rate, ext, amt, 24'(skew)};
		for (int k = 0; k < 6; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(k);
			cfg_data <= vals[k];
			@(posedge clk);
		end
		cfg_index <= REG_UNUSED;
		cfg_data <= 24'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		shape_q = kind;
		dur_q = longint'(dur);
		rate_q = longint'(signed'(rate));
		ext_q = longint'(signed'(ext));
		amt_q = longint'(signed'(amt));
		skew_q = longint'(signed'(skew));
		phase_count++;
	endtask

	task automatic drain;
		while (pending_times.size() > 0 || in_valid || expected_values.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 12) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_time();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 24'($urandom);
		if (sel == 1) return 24'($urandom_range(0, 200)) - 24'sd100;
		if (sel == 2) return 24'(ONE_I - 100 + $urandom_range(0, 200));
		return 24'($urandom_range(0, ONE_I));
	endfunction

	initial begin
		logic [2:0]  kind;
		logic [17:0] dur;
		logic [23:0] rate, ext, amt;
		logic [19:0] skew;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		beats_checked = 0;
		phase_count = 0;
		idle_on = 1'b0;
		shape_q = '0;
		dur_q = 0;
		rate_q = 0;
		ext_q = 0;
		amt_q = 0;
		skew_q = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: stable shape
		pending_times = '{24'sh80_0000, 24'sh7F_FFFF, 24'sd0};
		drain();
		set_regs(ptbe_pkg::SHAPE_ONSET, 18'(ONE_I / 4), 0, 0, 0, 0);
		pending_times = '{24'sd0, 24'(ONE_I / 4 - 1), 24'(ONE_I / 4), 24'(ONE_I - 1)};
		drain();
		set_regs(ptbe_pkg::SHAPE_RELEASE, 18'h3FFFF, 0, 0, 0, 0);
		pending_times = '{24'sd1, 24'(ONE_I), 24'(ONE_I + 1)};
		drain();
		set_regs(ptbe_pkg::SHAPE_RELEASE, 18'(ONE_I / 4), 0, 0, 0, 0);
		pending_times = '{24'(ONE_I * 3 / 4), 24'(ONE_I * 3 / 4 + 1)};
		drain();
		set_regs(ptbe_pkg::SHAPE_VIBRATO, 0, 24'h7FFFFF, 24'h7FFFFF, 0, 0);
		pending_times = '{24'(ONE_I / 3), 24'(ONE_I)};
		drain();
		set_regs(ptbe_pkg::SHAPE_VIBRATO, 0, 24'h800000, 24'h800000, 0, 0);
		pending_times = '{24'(ONE_I / 7), 24'(ONE_I / 2)};
		drain();
		set_regs(ptbe_pkg::SHAPE_ATTRACT, 0, 0, 0, 24'h800000, 20'h7FFFF);
		pending_times = '{24'sd0, 24'sd1, 24'(ONE_I / 2)};
		drain();
		set_regs(ptbe_pkg::SHAPE_ATTRACT, 0, 0, 0, 24'h7FFFFF, 20'h80000);
		pending_times = '{24'sd1, 24'(ONE_I - 1), 24'(ONE_I)};
		drain();
		set_regs(SHAPE_UNUSED, 18'h3FFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 20'h7FFFF);
		pending_times = '{24'(ONE_I / 2)};
		drain();

		for (int ph = 0; ph < 30; ph++) begin
			idle_on = (ph % 3 != 1);
			kind = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			dur = ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'($urandom_range(0, ONE_I));
			if ($urandom_range(0, 5) == 0) dur = 0;
			rate = ($urandom_range(0, 3) == 0) ? 24'($urandom)
				: 24'($urandom_range(0, 32 * ONE_I)) - 24'(16 * ONE_I);
			ext = 24'($urandom);
			amt = ($urandom_range(0, 1) == 0) ? 24'($urandom)
				: 24'($urandom_range(0, 4 * ONE_I)) - 24'(2 * ONE_I);
			skew = ($urandom_range(0, 3) == 0) ? 20'($urandom)
				: 20'($urandom_range(0, 6 * ONE_I)) - 20'(3 * ONE_I);
			set_regs(kind, dur, rate, ext, amt, skew);
			for (int k = 0; k < 62; k++)
				pending_times.push_back(($urandom_range(0, 4) == 0 && dur != 0)
					? 24'(dur) + 24'($urandom_range(0, 4)) - 24'sd2 : rand_time());
			drain();
		end

		$display("Checked %0d output beats over %0d register settings, all shapes included.",
			beats_checked, phase_count);
		if (fail_count == 0) begin
			$display("pitch_trajectory_basis_eval test passed");
		end else begin
			$display("pitch_trajectory_basis_eval test failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("pitch_trajectory_basis_eval test failed");
		$finish;
	end

endmodule

/* sim.f */
design/ptbe_pkg.sv
design/ptbe_exp2.sv
design/pitch_trajectory_basis_eval.sv
tb/pitch_trajectory_basis_eval_tb.sv
